/* design/tqft_pkg.sv */
// ----------------------------------------------------------------------------
// tqft_pkg
// Shared types and constants for the quoted-field tab-separated tokenizer.
// ----------------------------------------------------------------------------
package tqft_pkg;

  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    KindByte    = 3'd0,
    KindCellEnd = 3'd1,
    KindRowEnd  = 3'd2,
    KindOk      = 3'd3,
    KindErrOpen = 3'd4,
    KindErrEmpt = 3'd5
  } token_kind_e;

  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic cell_nonempty;
    logic row_has_cells;
    logic table_has_rows;
  } flags_t;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  tbyte;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } step_out_t;

endpackage

/* design/tqft_step.sv */
// ----------------------------------------------------------------------------
// tqft_step
// One tokenizer step: flags and one request in, next flags and up to two
// results out.
// ----------------------------------------------------------------------------
module tqft_step (
  input  tqft_pkg::flags_t    flags_i,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  output tqft_pkg::flags_t    flags_o,
  output tqft_pkg::step_out_t step_o
);

  logic iq;

  assign iq = flags_i.inside_quotes & ~flags_i.quote_pending;

  always_comb begin
    flags_o          = flags_i;
    step_o.num       = 2'd0;
    step_o.res0      = '{kind: tqft_pkg::KindByte, tbyte: 8'h00, last: 1'b1};
    step_o.res1      = '{kind: tqft_pkg::KindOk, tbyte: 8'h00, last: 1'b1};
    if (end_of_text_i) begin
      flags_o = '0;
      if (iq) begin
        step_o.num       = 2'd1;
        step_o.res0.kind = tqft_pkg::KindErrOpen;
      end else if (flags_i.cell_nonempty || flags_i.row_has_cells) begin
        step_o.num       = 2'd2;
        step_o.res0.kind = tqft_pkg::KindRowEnd;
        step_o.res0.last = 1'b0;
      end else begin
        step_o.num       = 2'd1;
        step_o.res0.kind = flags_i.table_has_rows ? tqft_pkg::KindOk
                                                  : tqft_pkg::KindErrEmpt;
      end
    end else if (flags_i.quote_pending && text_byte_i == tqft_pkg::CharQuote) begin
      flags_o.quote_pending = 1'b0;
      flags_o.cell_nonempty = 1'b1;
      step_o.num            = 2'd1;
      step_o.res0.tbyte     = tqft_pkg::CharQuote;
    end else begin
      flags_o.quote_pending = 1'b0;
      flags_o.inside_quotes = iq;
      priority if (text_byte_i == tqft_pkg::CharQuote) begin
        if (iq) begin
          flags_o.quote_pending = 1'b1;
        end else if (!flags_i.cell_nonempty) begin
          flags_o.inside_quotes = 1'b1;
        end else begin
          step_o.num        = 2'd1;
          step_o.res0.tbyte = text_byte_i;
        end
      end else if (text_byte_i == tqft_pkg::CharCr) begin
        step_o.num = 2'd0;
      end else if (text_byte_i == tqft_pkg::CharTab && !iq) begin
        step_o.num            = 2'd1;
        step_o.res0.kind      = tqft_pkg::KindCellEnd;
        flags_o.cell_nonempty = 1'b0;
        flags_o.row_has_cells = 1'b1;
      end else if (text_byte_i == tqft_pkg::CharLf && !iq) begin
        step_o.num             = 2'd1;
        step_o.res0.kind       = tqft_pkg::KindRowEnd;
        flags_o.cell_nonempty  = 1'b0;
        flags_o.row_has_cells  = 1'b0;
        flags_o.table_has_rows = 1'b1;
      end else begin
        step_o.num            = 2'd1;
        step_o.res0.tbyte     = text_byte_i;
        flags_o.cell_nonempty = 1'b1;
      end
    end
  end

endmodule

/* design/tqft_out_queue.sv */
// ----------------------------------------------------------------------------
// tqft_out_queue
// Small result queue: up to two results in per cycle, one out unless stalled.
// ----------------------------------------------------------------------------
module tqft_out_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tqft_pkg::step_out_t       push_i,
  output logic                      room2_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tqft_pkg::result_t         head_o
);

  tqft_pkg::result_t               mem_q [tqft_pkg::QueueDepth];
  logic [tqft_pkg::PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_1;
  logic [tqft_pkg::CntW-1:0]       count_q, count_d;
  logic                            pop;

  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = count_q != '0;
  assign room2_o     = count_q <= tqft_pkg::CntW'(tqft_pkg::QueueDepth - 2);
  assign head_o      = mem_q[rd_ptr_q];
  assign wr_ptr_1    = wr_ptr_q + tqft_pkg::PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + tqft_pkg::PtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + tqft_pkg::PtrW'(pop);
    count_d  = count_q + tqft_pkg::CntW'(push_i.num) - tqft_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_1] <= push_i.res1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tqft_pkg::CntW'(tqft_pkg::QueueDepth))
    else $error("result queue count over depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room2_o)
    else $error("push without room for two results");

  a_pair_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num == 2'd2 && !pop) |=> count_q == $past(count_q) + tqft_pkg::CntW'(2))
    else $error("double push lost an entry");

endmodule

/* design/tsv_quoted_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// tsv_quoted_field_tokenizer
// Tab-separated text tokenizer with quoted cells: one byte or end-of-text
// request in, cell bytes and cell/row/end markers out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o  | text_byte_i, end_of_text_i
//  out     | output    | out_valid_o / out_stall_i| token_kind_o, token_byte_o,
//          |           |                          | last_of_run_o
//
//  one request per cycle unless stalled; a byte request gives zero or one result
//  end-of-text gives one or two results; one leaves per cycle unless stalled
//  latency: input register, then step logic into a four-entry result queue
//  in_stall_o rises only while the queue lacks room for two results
//  reset clears flags, the input valid bit and the queue at once
// ----------------------------------------------------------------------------
module tsv_quoted_field_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       last_of_run_o
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                in_eot_q;
  logic                room2;
  logic                process;
  tqft_pkg::flags_t    flags_q, flags_d;
  tqft_pkg::step_out_t step_res, push;
  tqft_pkg::result_t   head;

  assign process    = in_valid_q & room2;
  assign in_stall_o = in_valid_q & ~room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      flags_q    <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (process) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= text_byte_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  tqft_step u_step (
    .flags_i       (flags_q),
    .text_byte_i   (in_byte_q),
    .end_of_text_i (in_eot_q),
    .flags_o       (flags_d),
    .step_o        (step_res)
  );

  always_comb begin
    push     = step_res;
    push.num = process ? step_res.num : 2'd0;
  end

  tqft_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign token_kind_o  = head.kind;
  assign token_byte_o  = head.tbyte;
  assign last_of_run_o = head.last;

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && in_eot_q) |=> flags_q == '0)
    else $error("flags not cleared after end of text");

  a_pending_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.quote_pending |-> flags_q.inside_quotes)
    else $error("pending quote outside quotes");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("stall with empty input register");

endmodule
